FILE: hw/rtl/htc_pkg.sv
// Shared types and constants for the hold-to-confirm prompt controller.
package htc_pkg;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_PROMPT = 2'd1,
    FUNC_CLOSE  = 2'd2
  } func_t;

  // Screen codes of a result beat.
  typedef enum logic [2:0] {
    SCR_NONE   = 3'd0,
    SCR_MENU   = 3'd1,
    SCR_CLAIM  = 3'd2,
    SCR_FINGER = 3'd3,
    SCR_COUNT  = 3'd4
  } screen_t;

  // Result codes of a trust result message.
  localparam logic RCODE_CONFIRMED = 1'b0;
  localparam logic RCODE_TIMEOUT   = 1'b1;

  // Session kind that selects menu behavior.
  localparam logic [1:0] KIND_MENU = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_TIMEOUT_LIMIT = 2'd0;
  localparam logic [1:0] REG_DISPLAY_LIMIT = 2'd1;
  localparam logic [1:0] REG_RELEASE_GRACE = 2'd2;

  // Configuration reset values.
  localparam logic [31:0] TIMEOUT_LIMIT_RST = 32'd150000;
  localparam logic [31:0] DISPLAY_LIMIT_RST = 32'd90000;
  localparam logic [3:0]  RELEASE_GRACE_RST = 4'd2;

  // Hold need in ms is at most 255 * 1000, which fits in 18 bits.
  localparam int unsigned NEED_W = 18;
  localparam logic [NEED_W-1:0] MS_PER_SEC = 18'd1000;
  localparam logic [NEED_W-1:0] ROUND_UP   = 18'd999;

  // Division by 1000 as a multiply by ceil(2^28 / 1000) and a shift by 28.
  // Exact for every dividend below 2^18.
  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned RECIP_W     = 19;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 19'd268436;

  localparam logic [4:0] MISS_MAX = 5'd31;

  // Input beat payload.
  typedef struct packed {
    logic [7:0]  prompt_req_seq;
    logic [31:0] prompt_nonce;
    logic [7:0]  prompt_confirm_secs;
    logic [1:0]  prompt_mode;
    logic        btn_right;
    logic        btn_left;
    logic [31:0] now_ms;
  } in_beat_t;

  // Output beat payload.
  typedef struct packed {
    logic        prompt_active;
    logic        beep;
    logic        right_press;
    logic        left_press;
    logic [7:0]  result_seq;
    logic [31:0] result_nonce;
    logic        result_code;
    logic        result_valid;
    logic [7:0]  countdown_secs;
    screen_t     screen;
  } out_beat_t;

  localparam int unsigned IN_BITS    = $bits(in_beat_t);
  localparam int unsigned OUT_BITS   = $bits(out_beat_t);
  localparam int unsigned IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

FILE: hw/rtl/hold_to_confirm_prompt_controller.sv
// Hold-to-confirm prompt controller: session state, hold timing and result beats.
// An accepted beat lands in the input register and then in the result register,
// which drives m_tdata; a stall on m_tready can hold it in either. Throughput: one
// beat per cycle, limited only by the downstream tready; the input register lets
// a new beat enter while a finished result waits in the result register.
// Reset (synchronous, active high) closes the session, empties both pipeline
// registers and restores the configuration defaults.
module hold_to_confirm_prompt_controller (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // tdata from bit 0: now_ms, btn_left, btn_right, prompt_mode,
  // prompt_confirm_secs, prompt_nonce, prompt_req_seq, zero fill.
  input  logic [htc_pkg::IN_DATA_W-1:0]       s_tdata,
  // tuser: func.
  input  logic [1:0]                          s_tuser,
  // Result stream.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // tdata from bit 0: screen, countdown_secs, result_valid, result_code,
  // result_nonce, result_seq, left_press, right_press, beep, prompt_active,
  // zero fill.
  output logic [htc_pkg::OUT_DATA_W-1:0]      m_tdata,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_addr,
  input  logic [31:0]                         cfg_wdata
);

  // Configuration registers.
  logic [31:0] timeout_limit_ms;
  logic [31:0] display_limit_ms;
  logic [3:0]  release_grace_samples;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit_ms      <= htc_pkg::TIMEOUT_LIMIT_RST;
      display_limit_ms      <= htc_pkg::DISPLAY_LIMIT_RST;
      release_grace_samples <= htc_pkg::RELEASE_GRACE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        htc_pkg::REG_TIMEOUT_LIMIT: timeout_limit_ms      <= cfg_wdata;
        htc_pkg::REG_DISPLAY_LIMIT: display_limit_ms      <= cfg_wdata;
        htc_pkg::REG_RELEASE_GRACE: release_grace_samples <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake. The result register advances whenever it is empty or
  // being drained, and the input register whenever it is empty or its beat moves on.
  logic                out_valid;
  htc_pkg::out_beat_t  out_beat;
  logic                s1_valid;
  logic [1:0]          s1_func;
  htc_pkg::in_beat_t   s1_beat;
  logic                out_ready;
  logic                s1_fire;

  assign out_ready = !out_valid || m_tready;
  assign s1_fire   = s1_valid && out_ready;
  assign s_tready  = !s1_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_func <= s_tuser;
      s1_beat <= htc_pkg::in_beat_t'(s_tdata[htc_pkg::IN_BITS-1:0]);
    end
  end

  // Session state.
  logic        session_open,  session_open_next;
  logic [1:0]  session_kind,  session_kind_next;
  logic [7:0]  hold_seconds,  hold_seconds_next;
  logic [31:0] saved_nonce,   saved_nonce_next;
  logic [7:0]  saved_seq,     saved_seq_next;
  logic [31:0] start_time,    start_time_next;
  logic [31:0] hold_time,     hold_time_next;
  logic        hold_running,  hold_running_next;
  logic [4:0]  miss_count,    miss_count_next;
  logic        menu_synced,   menu_synced_next;
  logic        last_left,     last_left_next;
  logic        last_right,    last_right_next;

  htc_pkg::out_beat_t out_beat_next;

  // Shared timing arithmetic for the tick path.
  logic [31:0]                        elapsed;
  logic [htc_pkg::NEED_W-1:0]         need;
  logic [31:0]                        hold_base;
  logic [31:0]                        held;
  logic                               hold_done;
  logic [htc_pkg::NEED_W-1:0]         remain_rnd;
  logic [htc_pkg::NEED_W+htc_pkg::RECIP_W-1:0] recip_prod;
  logic [7:0]                         countdown_val;
  logic                               both;
  logic                               timed_out;
  logic [4:0]                         miss_inc;

  always_comb begin
    elapsed   = s1_beat.now_ms - start_time;
    need      = htc_pkg::NEED_W'(hold_seconds) * htc_pkg::MS_PER_SEC;
    // A hold that starts on this tick measures from now, so it has held zero.
    hold_base = hold_running ? hold_time : s1_beat.now_ms;
    held      = s1_beat.now_ms - hold_base;
    hold_done = held >= 32'(need);
    // Only meaningful when the hold is short of the need, so held fits in 18 bits.
    remain_rnd = need - held[htc_pkg::NEED_W-1:0] + htc_pkg::ROUND_UP;
    recip_prod = (htc_pkg::NEED_W + htc_pkg::RECIP_W)'(remain_rnd)
               * (htc_pkg::NEED_W + htc_pkg::RECIP_W)'(htc_pkg::RECIP_1000);
    countdown_val = hold_done ? 8'd0 : recip_prod[htc_pkg::RECIP_SHIFT +: 8];
    both       = s1_beat.btn_left && s1_beat.btn_right;
    timed_out  = elapsed > timeout_limit_ms;
    miss_inc   = (miss_count < htc_pkg::MISS_MAX) ? miss_count + 5'd1 : miss_count;
  end

  always_comb begin
    session_open_next = session_open;
    session_kind_next = session_kind;
    hold_seconds_next = hold_seconds;
    saved_nonce_next  = saved_nonce;
    saved_seq_next    = saved_seq;
    start_time_next   = start_time;
    hold_time_next    = hold_time;
    hold_running_next = hold_running;
    miss_count_next   = miss_count;
    menu_synced_next  = menu_synced;
    last_left_next    = last_left;
    last_right_next   = last_right;
    out_beat_next     = '0;
    out_beat_next.screen = htc_pkg::SCR_NONE;

    unique case (s1_func)
      htc_pkg::FUNC_TICK: begin
        if (session_open) begin
          if (session_kind == htc_pkg::KIND_MENU) begin
            if (timed_out) begin
              out_beat_next.result_valid = 1'b1;
              out_beat_next.result_code  = htc_pkg::RCODE_TIMEOUT;
              session_open_next = 1'b0;
              hold_running_next = 1'b0;
              miss_count_next   = '0;
            end else begin
              // The first tick only learns the levels; later ticks report edges.
              if (menu_synced) begin
                out_beat_next.left_press  = s1_beat.btn_left && !last_left;
                out_beat_next.right_press = s1_beat.btn_right && !last_right;
              end
              menu_synced_next = 1'b1;
              last_left_next   = s1_beat.btn_left;
              last_right_next  = s1_beat.btn_right;
              out_beat_next.screen = htc_pkg::SCR_MENU;
            end
          end else if (hold_seconds == 8'd0) begin
            // Display-only sessions close without a message.
            if (elapsed > display_limit_ms) begin
              session_open_next = 1'b0;
              hold_running_next = 1'b0;
              miss_count_next   = '0;
            end else begin
              out_beat_next.screen = htc_pkg::SCR_CLAIM;
            end
          end else if (timed_out) begin
            out_beat_next.result_valid = 1'b1;
            out_beat_next.result_code  = htc_pkg::RCODE_TIMEOUT;
            session_open_next = 1'b0;
            hold_running_next = 1'b0;
            miss_count_next   = '0;
          end else if (both) begin
            miss_count_next = '0;
            if (!hold_running) begin
              hold_running_next = 1'b1;
              hold_time_next    = s1_beat.now_ms;
            end
            if (hold_done) begin
              out_beat_next.beep         = 1'b1;
              out_beat_next.result_valid = 1'b1;
              out_beat_next.result_code  = htc_pkg::RCODE_CONFIRMED;
              session_open_next = 1'b0;
              hold_running_next = 1'b0;
            end else begin
              out_beat_next.screen         = htc_pkg::SCR_COUNT;
              out_beat_next.countdown_secs = countdown_val;
            end
          end else if (hold_running) begin
            // A short release keeps the hold alive for a few ticks.
            miss_count_next = miss_inc;
            if (miss_inc <= 5'(release_grace_samples)) begin
              out_beat_next.screen         = htc_pkg::SCR_COUNT;
              out_beat_next.countdown_secs = countdown_val;
            end else begin
              hold_running_next    = 1'b0;
              out_beat_next.screen = htc_pkg::SCR_FINGER;
            end
          end else begin
            out_beat_next.screen = htc_pkg::SCR_FINGER;
          end
        end
      end
      htc_pkg::FUNC_PROMPT: begin
        session_kind_next = s1_beat.prompt_mode;
        hold_seconds_next = s1_beat.prompt_confirm_secs;
        saved_nonce_next  = s1_beat.prompt_nonce;
        saved_seq_next    = s1_beat.prompt_req_seq;
        start_time_next   = s1_beat.now_ms;
        hold_time_next    = '0;
        hold_running_next = 1'b0;
        miss_count_next   = '0;
        menu_synced_next  = 1'b0;
        session_open_next = 1'b1;
      end
      htc_pkg::FUNC_CLOSE: begin
        session_open_next = 1'b0;
        hold_running_next = 1'b0;
        miss_count_next   = '0;
        hold_time_next    = '0;
      end
      default: ;
    endcase

    if (out_beat_next.result_valid) begin
      out_beat_next.result_nonce = saved_nonce;
      out_beat_next.result_seq   = saved_seq;
    end
    out_beat_next.prompt_active = session_open_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      session_open <= 1'b0;
      session_kind <= '0;
      hold_seconds <= '0;
      saved_nonce  <= '0;
      saved_seq    <= '0;
      start_time   <= '0;
      hold_time    <= '0;
      hold_running <= 1'b0;
      miss_count   <= '0;
      menu_synced  <= 1'b0;
      last_left    <= 1'b0;
      last_right   <= 1'b0;
    end else if (s1_fire) begin
      session_open <= session_open_next;
      session_kind <= session_kind_next;
      hold_seconds <= hold_seconds_next;
      saved_nonce  <= saved_nonce_next;
      saved_seq    <= saved_seq_next;
      start_time   <= start_time_next;
      hold_time    <= hold_time_next;
      hold_running <= hold_running_next;
      miss_count   <= miss_count_next;
      menu_synced  <= menu_synced_next;
      last_left    <= last_left_next;
      last_right   <= last_right_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_beat <= out_beat_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = htc_pkg::OUT_DATA_W'(out_beat);

`ifndef SYNTHESIS
  // A result message always ends the session, so nothing is on screen.
  a_result_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_beat.result_valid |->
      out_beat.screen == htc_pkg::SCR_NONE && !out_beat.prompt_active)
    else $error("result beat with a screen or an open session");

  // The beep comes only with a confirmed result.
  a_beep_confirmed: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_beat.beep |->
      out_beat.result_valid && out_beat.result_code == htc_pkg::RCODE_CONFIRMED)
    else $error("beep without a confirmed result");

  // A countdown value is shown only on the countdown screen.
  a_countdown_screen: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_beat.countdown_secs != 8'd0 |->
      out_beat.screen == htc_pkg::SCR_COUNT)
    else $error("countdown value off the countdown screen");

  // A hold can only run inside an open session.
  a_hold_in_session: assert property (@(posedge clk) disable iff (rst)
    hold_running |-> session_open)
    else $error("hold running with the session closed");
`endif

endmodule

FILE: tb/hold_to_confirm_prompt_controller_tb.sv
// Self-checking testbench for the hold-to-confirm prompt controller.
module hold_to_confirm_prompt_controller_tb;

  // Item kind that the block must ignore; tuser is two bits wide, so it can occur.
  localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

  // Cycles with no beat accepted on either side before the run is declared hung.
  localparam int STALL_LIMIT = 4000;

  // Result beats pass through the input and result registers; this covers that
  // with margin.
  localparam int TAIL_CYCLES = 6;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [htc_pkg::IN_DATA_W-1:0]  s_tdata;
  logic [1:0]                     s_tuser;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [htc_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           cfg_we;
  logic [1:0]                     cfg_addr;
  logic [31:0]                    cfg_wdata;

  hold_to_confirm_prompt_controller dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Controller shadow: the testbench's own copy of the registers and session
  // state. It starts at the reset values of the block.
  // ---------------------------------------------------------------------------
  logic [31:0] cfg_timeout = htc_pkg::TIMEOUT_LIMIT_RST;
  logic [31:0] cfg_display = htc_pkg::DISPLAY_LIMIT_RST;
  logic [3:0]  cfg_grace   = htc_pkg::RELEASE_GRACE_RST;

  logic        sess_open   = 1'b0;
  logic [1:0]  sess_kind   = 2'd0;
  logic [7:0]  hold_secs   = 8'd0;
  logic [31:0] kept_nonce  = 32'd0;
  logic [7:0]  kept_seq    = 8'd0;
  logic [31:0] opened_at   = 32'd0;
  logic [31:0] hold_start  = 32'd0;
  logic        holding     = 1'b0;
  logic [4:0]  misses      = 5'd0;
  logic        menu_primed = 1'b0;
  logic        prev_left   = 1'b0;
  logic        prev_right  = 1'b0;

  // Result beats owed by the block, oldest first.
  htc_pkg::out_beat_t ui_backlog[$];

  int error_count = 0;
  int items_sent  = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int quiet_cycles = 0;

  // Running millisecond clock used by the random sessions.
  logic [31:0] wall_ms;

  // Whole seconds still to hold, rounded up; zero once the need is met.
  function automatic logic [7:0] secs_to_go(logic [31:0] need, logic [31:0] held);
    logic [31:0] q;
    if (held >= need) return 8'd0;
    q = (need - held + 32'd999) / 32'd1000;
    return q[7:0];
  endfunction

  // A result message carries the stored nonce and sequence of the session.
  function automatic htc_pkg::out_beat_t with_result(logic code);
    htc_pkg::out_beat_t o;
    o = '0;
    o.result_valid = 1'b1;
    o.result_code  = code;
    o.result_nonce = kept_nonce;
    o.result_seq   = kept_seq;
    return o;
  endfunction

  function automatic void end_session();
    sess_open = 1'b0;
    holding   = 1'b0;
    misses    = 5'd0;
  endfunction

  // Advances the shadow by one accepted item and returns the beat it causes.
  function automatic htc_pkg::out_beat_t apply_item(logic [1:0] fn, htc_pkg::in_beat_t b);
    htc_pkg::out_beat_t o;
    logic [31:0]        elapsed;
    logic [31:0]        need;
    logic [31:0]        held;
    logic               show_finger;
    o = '0;
    case (fn)
      htc_pkg::FUNC_TICK: begin
        elapsed = b.now_ms - opened_at;
        need    = {24'd0, hold_secs} * 32'd1000;
        if (!sess_open) begin
          // A tick while closed leaves everything as it is.
        end else if (sess_kind == htc_pkg::KIND_MENU) begin
          if (elapsed > cfg_timeout) begin
            o = with_result(htc_pkg::RCODE_TIMEOUT);
            end_session();
          end else begin
            // The first tick of a menu session only learns the button levels.
            if (menu_primed) begin
              o.left_press  = b.btn_left & ~prev_left;
              o.right_press = b.btn_right & ~prev_right;
            end
            menu_primed = 1'b1;
            prev_left   = b.btn_left;
            prev_right  = b.btn_right;
            o.screen    = htc_pkg::SCR_MENU;
          end
        end else if (hold_secs == 8'd0) begin
          // Display-only sessions close without sending anything.
          if (elapsed > cfg_display) end_session();
          else o.screen = htc_pkg::SCR_CLAIM;
        end else if (elapsed > cfg_timeout) begin
          o = with_result(htc_pkg::RCODE_TIMEOUT);
          end_session();
        end else if (b.btn_left && b.btn_right) begin
          misses = 5'd0;
          if (!holding) begin
            holding    = 1'b1;
            hold_start = b.now_ms;
          end
          held = b.now_ms - hold_start;
          if (held >= need) begin
            o = with_result(htc_pkg::RCODE_CONFIRMED);
            o.beep = 1'b1;
            end_session();
          end else begin
            o.screen         = htc_pkg::SCR_COUNT;
            o.countdown_secs = secs_to_go(need, held);
          end
        end else begin
          // A released button is forgiven for a few ticks while a hold runs.
          show_finger = 1'b1;
          if (holding) begin
            if (misses != htc_pkg::MISS_MAX) misses = misses + 5'd1;
            if (misses <= {1'b0, cfg_grace}) begin
              o.screen         = htc_pkg::SCR_COUNT;
              o.countdown_secs = secs_to_go(need, b.now_ms - hold_start);
              show_finger      = 1'b0;
            end else begin
              holding = 1'b0;
            end
          end
          if (show_finger) o.screen = htc_pkg::SCR_FINGER;
        end
      end
      htc_pkg::FUNC_PROMPT: begin
        sess_kind   = b.prompt_mode;
        hold_secs   = b.prompt_confirm_secs;
        kept_nonce  = b.prompt_nonce;
        kept_seq    = b.prompt_req_seq;
        opened_at   = b.now_ms;
        hold_start  = 32'd0;
        holding     = 1'b0;
        misses      = 5'd0;
        menu_primed = 1'b0;
        sess_open   = 1'b1;
      end
      htc_pkg::FUNC_CLOSE: begin
        end_session();
        hold_start = 32'd0;
      end
      default: begin
        // Unknown kinds change nothing.
      end
    endcase
    o.prompt_active = sess_open;
    return o;
  endfunction

  function automatic string fmt_beat(htc_pkg::out_beat_t b);
    return $sformatf({"scr=%0d cd=%0d rv=%0d rc=%0d nonce=%h seq=%0d ",
                      "lp=%0d rp=%0d beep=%0d act=%0d"},
                     b.screen, b.countdown_secs, b.result_valid, b.result_code,
                     b.result_nonce, b.result_seq, b.left_press, b.right_press,
                     b.beep, b.prompt_active);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking. Each accepted result beat is matched against the oldest
  // owed beat; a beat with nothing owed is a failure as well.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    htc_pkg::out_beat_t got;
    htc_pkg::out_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = htc_pkg::out_beat_t'(m_tdata[htc_pkg::OUT_BITS-1:0]);
      if (ui_backlog.size() == 0) begin
        error_count = error_count + 1;
        if (error_count <= 10)
          $display("ERROR: result beat with nothing owed: %s", fmt_beat(got));
      end else begin
        want = ui_backlog.pop_front();
        if (got.screen !== want.screen || got.countdown_secs !== want.countdown_secs ||
            got.result_valid !== want.result_valid || got.result_code !== want.result_code ||
            got.result_nonce !== want.result_nonce || got.result_seq !== want.result_seq ||
            got.left_press !== want.left_press || got.right_press !== want.right_press ||
            got.beep !== want.beep || got.prompt_active !== want.prompt_active) begin
          error_count = error_count + 1;
          if (error_count <= 10) begin
            $display("ERROR: result beat mismatch at %0t", $realtime);
            $display("  expected %s", fmt_beat(want));
            $display("  actual   %s", fmt_beat(got));
          end
        end
      end
    end
  end

  // The receiver stalls at random; the percentage is set per traffic phase.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Hang detection: any accepted beat on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("hold_to_confirm_prompt_controller verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Presents one beat, with random sender gaps ahead of it, and waits until it
  // is taken. The valid stays high afterward so back-to-back beats need no
  // second assignment in one time step; settle() lowers it.
  task automatic send_item(input logic [1:0] fn, input htc_pkg::in_beat_t b);
    logic [htc_pkg::IN_DATA_W-1:0] packed_beat;
    packed_beat = '0;
    packed_beat[htc_pkg::IN_BITS-1:0] = b;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= packed_beat;
    do @(posedge clk); while (!s_tready);
    ui_backlog.push_back(apply_item(fn, b));
    items_sent = items_sent + 1;
  endtask

  // Random content for the fields an item does not use.
  function automatic htc_pkg::in_beat_t noise_beat();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return htc_pkg::in_beat_t'(bits[htc_pkg::IN_BITS-1:0]);
  endfunction

  task automatic tick(input logic [31:0] now, input logic l, input logic r);
    htc_pkg::in_beat_t b;
    b = noise_beat();
    b.now_ms    = now;
    b.btn_left  = l;
    b.btn_right = r;
    send_item(htc_pkg::FUNC_TICK, b);
  endtask

  task automatic prompt(input logic [31:0] now, input logic [1:0] mode,
                        input logic [7:0] secs, input logic [31:0] nonce,
                        input logic [7:0] seq);
    htc_pkg::in_beat_t b;
    b = noise_beat();
    b.now_ms              = now;
    b.prompt_mode         = mode;
    b.prompt_confirm_secs = secs;
    b.prompt_nonce        = nonce;
    b.prompt_req_seq      = seq;
    send_item(htc_pkg::FUNC_PROMPT, b);
  endtask

  // Stops sending and waits until every owed result has come, then lets the
  // pipeline drain fully so the block is idle.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (ui_backlog.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic program_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      htc_pkg::REG_TIMEOUT_LIMIT: cfg_timeout = val;
      htc_pkg::REG_DISPLAY_LIMIT: cfg_display = val;
      htc_pkg::REG_RELEASE_GRACE: cfg_grace   = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_all(input logic [31:0] timeout_ms, input logic [31:0] display_ms,
                             input logic [3:0] grace);
    program_reg(htc_pkg::REG_TIMEOUT_LIMIT, timeout_ms);
    program_reg(htc_pkg::REG_DISPLAY_LIMIT, display_ms);
    program_reg(htc_pkg::REG_RELEASE_GRACE, {28'd0, grace});
  endtask

  // One random session: mostly well-formed prompts followed by ticks whose
  // button pattern suits the session kind, with the odd stray item mixed in.
  task automatic random_session();
    int          pick;
    int          ticks;
    int          k;
    int          step_pick;
    logic [1:0]  mode;
    logic [7:0]  secs;
    logic        l;
    logic        r;
    pick = $urandom_range(99);
    if (pick < 8) begin
      case ($urandom_range(2))
        0: tick(wall_ms, 1'($urandom_range(1)), 1'($urandom_range(1)));
        1: send_item(FUNC_UNKNOWN, noise_beat());
        default: send_item(htc_pkg::FUNC_CLOSE, noise_beat());
      endcase
    end else begin
      if (pick < 50) begin
        // Confirm session: any mode but menu, mostly short holds.
        case ($urandom_range(2))
          0: mode = 2'd0;
          1: mode = 2'd1;
          default: mode = 2'd3;
        endcase
        secs = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(1, 4));
      end else if (pick < 78) begin
        mode = htc_pkg::KIND_MENU;
        secs = 8'($urandom_range(255));
      end else begin
        mode = 2'($urandom_range(3));
        if (mode == htc_pkg::KIND_MENU) mode = 2'd0;
        secs = 8'd0;
      end
      wall_ms = wall_ms + $urandom_range(0, 3000);
      prompt(wall_ms, mode, secs, $urandom, 8'($urandom_range(255)));
      ticks = $urandom_range(2, 40);
      k = 0;
      while (sess_open && k < ticks) begin
        step_pick = $urandom_range(99);
        if (step_pick < 88) wall_ms = wall_ms + $urandom_range(0, 600);
        else if (step_pick < 98) wall_ms = wall_ms + $urandom_range(600, 20000);
        else wall_ms = wall_ms + $urandom;
        if (mode != htc_pkg::KIND_MENU && $urandom_range(3) != 0) begin
          l = 1'b1;
          r = 1'b1;
        end else begin
          l = 1'($urandom_range(1));
          r = 1'($urandom_range(1));
        end
        if ($urandom_range(49) == 0) send_item(FUNC_UNKNOWN, noise_beat());
        tick(wall_ms, l, r);
        k = k + 1;
      end
      if (sess_open && $urandom_range(4) == 0) send_item(htc_pkg::FUNC_CLOSE, noise_beat());
    end
    // Now and then the sender waits for every owed result before going on.
    if ($urandom_range(29) == 0) settle();
  endtask

  task automatic run_sessions(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) random_session();
  endtask

  // ---------------------------------------------------------------------------
  // Tests. The directed ones run at reset configuration with no idling.
  // ---------------------------------------------------------------------------

  // Before any prompt a tick does nothing, and an unknown kind is ignored.
  task automatic test_closed_and_unknown();
    send_item(htc_pkg::FUNC_TICK, '1);
    send_item(FUNC_UNKNOWN, '1);
  endtask

  // Display-only session across a time wrap, closing just past its limit.
  task automatic test_display_session();
    logic [31:0] t0;
    t0 = 32'hFFFF_FF00;
    prompt(t0, 2'd0, 8'd0, 32'hFFFF_FFFF, 8'hFF);
    tick(32'h0000_0100, 1'b1, 1'b1);
    send_item(FUNC_UNKNOWN, '0);
    tick(t0 + htc_pkg::DISPLAY_LIMIT_RST, 1'b0, 1'b0);
    tick(t0 + htc_pkg::DISPLAY_LIMIT_RST + 32'd1, 1'b0, 1'b0);
    tick(t0 + htc_pkg::DISPLAY_LIMIT_RST + 32'd2, 1'b1, 1'b1);
  endtask

  // Longest hold, release grace running out, then a timeout result.
  task automatic test_confirm_hold();
    logic [31:0] t0;
    t0 = 32'h0000_1000;
    prompt(t0, 2'd3, 8'd255, 32'd0, 8'd0);
    tick(t0, 1'b1, 1'b1);
    tick(t0 + 32'd1, 1'b1, 1'b1);
    tick(t0 + 32'd1001, 1'b1, 1'b0);
    tick(t0 + 32'd1002, 1'b0, 1'b1);
    tick(t0 + 32'd1003, 1'b0, 1'b0);
    tick(t0 + htc_pkg::TIMEOUT_LIMIT_RST, 1'b0, 1'b0);
    tick(t0 + htc_pkg::TIMEOUT_LIMIT_RST + 32'd1, 1'b1, 1'b1);
  endtask

  // A release after the need is met shows a zero countdown; the next full
  // press confirms with a beep.
  task automatic test_grace_clamp();
    logic [31:0] t0;
    t0 = 32'h8000_0000;
    prompt(t0, 2'd1, 8'd1, 32'hFFFF_FFFF, 8'hFF);
    tick(t0, 1'b1, 1'b1);
    tick(t0 + 32'd1500, 1'b0, 1'b0);
    tick(t0 + 32'd1600, 1'b1, 1'b1);
  endtask

  // Menu: the first tick only syncs, later ticks report rising levels.
  task automatic test_menu_session();
    logic [31:0] t0;
    t0 = 32'h1234_5678;
    prompt(t0, htc_pkg::KIND_MENU, 8'd7, 32'hA5A5_5A5A, 8'h3C);
    tick(t0 + 32'd10, 1'b1, 1'b1);
    tick(t0 + 32'd20, 1'b0, 1'b0);
    tick(t0 + 32'd30, 1'b1, 1'b1);
    tick(t0 + 32'd40, 1'b1, 1'b0);
    tick(t0 + htc_pkg::TIMEOUT_LIMIT_RST + 32'd1, 1'b0, 1'b1);
  endtask

  // Force close in the middle of a hold.
  task automatic test_force_close();
    prompt(32'd0, 2'd0, 8'd2, 32'h0000_0001, 8'h01);
    tick(32'd5, 1'b1, 1'b1);
    send_item(htc_pkg::FUNC_CLOSE, '1);
    tick(32'd10, 1'b1, 1'b1);
  endtask

  // Extreme register settings: limits of zero expire at once, full-scale
  // limits never do; grace from none to the largest.
  task automatic test_register_extremes();
    settle();
    program_all(32'd0, 32'd0, 4'd0);
    run_sessions(60);
    settle();
    program_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    run_sessions(60);
  endtask

  // Random traffic under one idling pattern and a fresh register setting.
  task automatic test_random_traffic(input int sender_idle, input int receiver_stall);
    settle();
    program_all($urandom_range(5000, 40000), $urandom_range(500, 10000),
                4'($urandom_range(15)));
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    run_sessions(350);
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = htc_pkg::FUNC_TICK;
    cfg_we    = 1'b0;
    cfg_addr  = htc_pkg::REG_TIMEOUT_LIMIT;
    cfg_wdata = 32'd0;
    wall_ms   = $urandom;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_closed_and_unknown();
    test_display_session();
    test_confirm_hold();
    test_grace_clamp();
    test_menu_session();
    test_force_close();
    test_register_extremes();
    test_random_traffic(0, 0);
    test_random_traffic(87, 0);
    test_random_traffic(0, 87);
    test_random_traffic(16, 16);
    settle();

    if (error_count == 0 && ui_backlog.size() == 0) begin
      $display("hold_to_confirm_prompt_controller verification clean");
    end else begin
      $display("hold_to_confirm_prompt_controller verification failed");
    end
    $finish;
  end

endmodule
